[rtl/core/pibr_pkg.sv]
// shared types, constants and register map for the pulse interval byte receiver
package pibr_pkg;

  localparam int BITS_PER_FRAME_DEF = 8;
  localparam int INTERVAL_WIDTH_DEF = 16;

  localparam int REG_W      = 10;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [REG_W-1:0] OFFSET_RST    = REG_W'(50);
  localparam logic [REG_W-1:0] ONE_WIDTH_RST = REG_W'(150);
  localparam logic [REG_W-1:0] ZERO_WIDTH_RST = REG_W'(50);
  localparam logic [REG_W-1:0] TOLERANCE_RST = REG_W'(20);

  typedef enum logic [1:0] {
    REG_OFFSET     = 2'd0,
    REG_ONE_WIDTH  = 2'd1,
    REG_ZERO_WIDTH = 2'd2,
    REG_TOLERANCE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] offset_ticks;
    logic [REG_W-1:0] one_width;
    logic [REG_W-1:0] zero_width;
    logic [REG_W-1:0] tolerance;
  } cfg_regs_t;

  typedef struct packed {
    logic       produced;
    logic       bit_value;
    logic       bit_valid;
    logic [2:0] bit_index;
    logic [7:0] byte_value;
    logic       byte_done;
  } result_t;

  typedef struct packed {
    logic frame_open;
    logic edge_phase;
    logic count_zero;
    logic count_full;
    logic count_over;
  } frame_status_t;

endpackage

[rtl/core/pibr_cfg.sv]
// apb register block holding the timing windows
module pibr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pibr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [pibr_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [pibr_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output pibr_pkg::cfg_regs_t               regs
);

  pibr_pkg::cfg_regs_t regs_r;
  pibr_pkg::cfg_regs_t regs_nxt;
  pibr_pkg::reg_idx_t  idx;
  logic                wr_en;
  logic [pibr_pkg::REG_W-1:0] wval;

  assign idx   = pibr_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign wval  = cfg_pwdata[pibr_pkg::REG_W-1:0];

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (idx)
        pibr_pkg::REG_OFFSET:     regs_nxt.offset_ticks = wval;
        pibr_pkg::REG_ONE_WIDTH:  regs_nxt.one_width    = wval;
        pibr_pkg::REG_ZERO_WIDTH: regs_nxt.zero_width   = wval;
        pibr_pkg::REG_TOLERANCE:  regs_nxt.tolerance    = wval;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.offset_ticks <= pibr_pkg::OFFSET_RST;
      regs_r.one_width    <= pibr_pkg::ONE_WIDTH_RST;
      regs_r.zero_width   <= pibr_pkg::ZERO_WIDTH_RST;
      regs_r.tolerance    <= pibr_pkg::TOLERANCE_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  always_comb begin
    case (idx)
      pibr_pkg::REG_OFFSET:     cfg_prdata = pibr_pkg::CFG_DATA_W'(regs_r.offset_ticks);
      pibr_pkg::REG_ONE_WIDTH:  cfg_prdata = pibr_pkg::CFG_DATA_W'(regs_r.one_width);
      pibr_pkg::REG_ZERO_WIDTH: cfg_prdata = pibr_pkg::CFG_DATA_W'(regs_r.zero_width);
      pibr_pkg::REG_TOLERANCE:  cfg_prdata = pibr_pkg::CFG_DATA_W'(regs_r.tolerance);
      default:                  cfg_prdata = '0;
    endcase
  end

  assign regs = regs_r;

endmodule

[rtl/core/pibr_frame.sv]
// edge detect, interval measure, window compare and bit assembly for one sample
module pibr_frame #(
  parameter int BITS_PER_FRAME = pibr_pkg::BITS_PER_FRAME_DEF,
  parameter int INTERVAL_WIDTH = pibr_pkg::INTERVAL_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic                     level,
  input  pibr_pkg::cfg_regs_t      regs,
  output pibr_pkg::result_t        res,
  output pibr_pkg::frame_status_t  status
);

  localparam int CNT_W = $clog2(BITS_PER_FRAME + 1);
  // signed compare width: holds the interval plus the widest window bound
  localparam int CW    = ((INTERVAL_WIDTH > 12) ? INTERVAL_WIDTH : 12) + 2;
  localparam int XW    = CW - pibr_pkg::REG_W;

  logic                      prev_level_r, prev_level_nxt;
  logic                      edge_phase_r, edge_phase_nxt;
  logic                      frame_open_r, frame_open_nxt;
  logic [CNT_W-1:0]          bits_taken_r, bits_taken_nxt;
  logic [INTERVAL_WIDTH-1:0] interval_r, interval_nxt;
  logic [BITS_PER_FRAME-1:0] store_r, store_nxt;

  logic                      line_edge;
  logic                      phase_t;
  logic [INTERVAL_WIDTH-1:0] measured;
  logic [BITS_PER_FRAME-1:0] mask;
  logic signed [CW-1:0]      meas_s, off_s, one_s, zero_s, tol_s;
  logic signed [CW-1:0]      one_lo, one_hi, zero_lo, zero_hi;
  logic                      one_hit, zero_hit;

  assign line_edge = level != prev_level_r;
  assign phase_t   = ~edge_phase_r;
  // saturating tick count, taken at the edge tick itself
  assign measured  = (interval_r == '1) ? interval_r : interval_r + 1'b1;

  assign meas_s = $signed({{(CW-INTERVAL_WIDTH){1'b0}}, measured});
  assign off_s  = $signed({{XW{1'b0}}, regs.offset_ticks});
  assign one_s  = $signed({{XW{1'b0}}, regs.one_width});
  assign zero_s = $signed({{XW{1'b0}}, regs.zero_width});
  assign tol_s  = $signed({{XW{1'b0}}, regs.tolerance});

  // window bounds moved onto the raw interval by adding the offset
  assign one_lo  = one_s - tol_s + off_s;
  assign one_hi  = one_s + tol_s + off_s;
  assign zero_lo = zero_s - tol_s + off_s;
  assign zero_hi = zero_s + tol_s + off_s;

  assign one_hit  = (meas_s > one_lo) && (meas_s < one_hi);
  assign zero_hit = (meas_s > zero_lo) && (meas_s < zero_hi);

  always_comb begin
    for (int i = 0; i < BITS_PER_FRAME; i++) begin
      mask[i] = bits_taken_r == CNT_W'(BITS_PER_FRAME - 1 - i);
    end
  end

  always_comb begin
    prev_level_nxt = level;
    edge_phase_nxt = edge_phase_r;
    frame_open_nxt = frame_open_r;
    bits_taken_nxt = bits_taken_r;
    interval_nxt   = measured;
    store_nxt      = store_r;
    res            = '0;
    if (line_edge) begin
      edge_phase_nxt = phase_t;
      if (!frame_open_r) begin
        frame_open_nxt = 1'b1;
        bits_taken_nxt = '0;
        interval_nxt   = '0;
      end else if (bits_taken_r >= CNT_W'(BITS_PER_FRAME)) begin
        // closing edge after the last bit
        if (phase_t) begin
          frame_open_nxt = 1'b0;
          bits_taken_nxt = '0;
          edge_phase_nxt = 1'b1;
        end
      end else if (!phase_t) begin
        if (one_hit) begin
          store_nxt = store_r | mask;
        end else if (zero_hit) begin
          store_nxt = store_r & ~mask;
        end
        interval_nxt   = '0;
        bits_taken_nxt = bits_taken_r + 1'b1;
        res.produced   = 1'b1;
        res.bit_value  = |(store_nxt & mask);
        res.bit_valid  = one_hit || zero_hit;
        res.bit_index  = 3'(bits_taken_r);
        res.byte_value = 8'(store_nxt);
        res.byte_done  = bits_taken_r == CNT_W'(BITS_PER_FRAME - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b1;
      edge_phase_r <= 1'b1;
      frame_open_r <= 1'b0;
      bits_taken_r <= '0;
      interval_r   <= '0;
      store_r      <= '0;
    end else if (step) begin
      prev_level_r <= prev_level_nxt;
      edge_phase_r <= edge_phase_nxt;
      frame_open_r <= frame_open_nxt;
      bits_taken_r <= bits_taken_nxt;
      interval_r   <= interval_nxt;
      store_r      <= store_nxt;
    end
  end

  assign status.frame_open = frame_open_r;
  assign status.edge_phase = edge_phase_r;
  assign status.count_zero = bits_taken_r == '0;
  assign status.count_full = bits_taken_r == CNT_W'(BITS_PER_FRAME);
  assign status.count_over = bits_taken_r > CNT_W'(BITS_PER_FRAME);

endmodule

[rtl/core/pulse_interval_byte_receiver_core.sv]
// top level: sample register, frame decoder, result register and apb registers
// a sample is decoded while it sits in the sample register; its result is captured in
//   the result register, which raises out_tvalid until the result transfers
// throughput: one sample per cycle unless its result would land on a held result, set
//   by the combinational decode between the sample register and the result register
// reset: synchronous active-low rst_n clears the frame state, the sample and result
//   valid flags and the timing registers to their defaults
module pulse_interval_byte_receiver_core #(
  parameter int BITS_PER_FRAME = pibr_pkg::BITS_PER_FRAME_DEF,
  parameter int INTERVAL_WIDTH = pibr_pkg::INTERVAL_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,    // [0] line_level
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,   // [0] bit_value, [3:1] bit_index,
                                                       // [11:4] byte_value
  output logic [0:0]                      out_tuser,   // [0] bit_valid
  output logic                            out_tlast,   // byte_done
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pibr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pibr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pibr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  pibr_pkg::cfg_regs_t     regs;
  pibr_pkg::result_t       res;
  pibr_pkg::frame_status_t status;

  logic       in_valid_r;
  logic       in_level_r;
  logic       advance;
  logic       out_valid_r;
  logic       out_bit_r;
  logic       out_ok_r;
  logic [2:0] out_index_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  assign cfg_pready = 1'b1;

  pibr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .regs        (regs)
  );

  pibr_frame #(
    .BITS_PER_FRAME (BITS_PER_FRAME),
    .INTERVAL_WIDTH (INTERVAL_WIDTH)
  ) u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .level  (in_level_r),
    .regs   (regs),
    .res    (res),
    .status (status)
  );

  // a sample moves on unless its result would land on a held result
  assign advance   = in_valid_r && (!out_valid_r || out_tready || !res.produced);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_level_r <= in_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.produced) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.produced) begin
      out_bit_r   <= res.bit_value;
      out_ok_r    <= res.bit_valid;
      out_index_r <= res.bit_index;
      out_byte_r  <= res.byte_value;
      out_last_r  <= res.byte_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_byte_r, out_index_r, out_bit_r};
  assign out_tuser  = out_ok_r;
  assign out_tlast  = out_last_r;

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !status.frame_open |-> (status.count_zero && status.edge_phase))
    else $error("frame closed with bit count or phase not at rest");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !status.count_over)
    else $error("bit count beyond frame length");

  a_last_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.produced && res.byte_done) |=> status.count_full)
    else $error("last bit did not fill the frame count");

  a_sample_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_level_r)))
    else $error("stalled sample lost from the sample register");

endmodule
